// File: rtl/core/b2da_pkg.sv
// shared types and constants for the binary to decimal ascii converter
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic load;
    logic shift;
    logic trim;
    logic pop;
  } b2da_cmd_t;

  typedef struct packed {
    logic shift_last;
    logic top_zero;
    logic one_left;
  } b2da_status_t;

endpackage

// File: rtl/core/binary_to_decimal_ascii.sv
// top level: unsigned binary to decimal ascii digit stream
// the first digit is offered after the serial shift step and the trim step, which
// drops the leading zeros; a new value is taken only after the last digit of the
// previous one is sent; one character per cycle on output while m_axis_tready is high
// reset clears the controller to idle and the counters; data registers are not reset
`timescale 1ns / 1ps

module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // value
  input  logic [((VALUE_BITS + 7) / 8)*8-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // digit_char, then zero fill
  output logic [7:0]                          m_axis_tdata,
  // last_digit
  output logic                                m_axis_tlast
);

  localparam int unsigned DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;

  b2da_cmd_t cmd;
  b2da_status_t status;
  logic [CHAR_W-1:0] digit_char;

  b2da_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  b2da_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (s_axis_tdata[VALUE_BITS-1:0]),
    .status_o     (status),
    .digit_char_o (digit_char),
    .last_digit_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{(8-CHAR_W){1'b0}}, digit_char};

endmodule

// File: rtl/core/b2da_datapath.sv
// double dabble shift register, leading zero trim and digit output
`timescale 1ns / 1ps

module b2da_datapath import b2da_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned DIGITS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b2da_cmd_t             cmd_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output b2da_status_t          status_o,
  output logic [CHAR_W-1:0]     digit_char_o,
  output logic                  last_digit_o
);

  localparam int unsigned BCD_W = DIGITS * DIGIT_W;
  localparam int unsigned SHIFT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned CNT_W = $clog2(DIGITS + 1);
  localparam logic [DIGIT_W-1:0] ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD = 4'd3;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d, adj;
  logic [SHIFT_W-1:0] shift_cnt_q, shift_cnt_d;
  logic [CNT_W-1:0] dig_cnt_q, dig_cnt_d;
  logic [DIGIT_W-1:0] top_digit;

  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < int'(DIGITS); i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= ADJ_MIN) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    shift_cnt_d = shift_cnt_q;
    dig_cnt_d = dig_cnt_q;
    if (cmd_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
      shift_cnt_d = '0;
      dig_cnt_d = CNT_W'(DIGITS);
    end else if (cmd_i.shift) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      shift_cnt_d = shift_cnt_q + 1'b1;
    end else if (cmd_i.trim || cmd_i.pop) begin
      bcd_d = {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      dig_cnt_d = dig_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      shift_cnt_q <= shift_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];

  assign status_o.shift_last = (shift_cnt_q == SHIFT_W'(VALUE_BITS - 1));
  assign status_o.top_zero = (top_digit == '0);
  assign status_o.one_left = (dig_cnt_q == CNT_W'(1));

  assign digit_char_o = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
  assign last_digit_o = status_o.one_left;

endmodule

// File: rtl/core/b2da_ctrl.sv
// controller state machine for the binary to decimal ascii converter
`timescale 1ns / 1ps

module b2da_ctrl import b2da_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  b2da_status_t status_i,
  output b2da_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CONVERT = 4'b0010,
    ST_TRIM    = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd_o.shift = 1'b1;
        if (status_i.shift_last) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (status_i.top_zero && !status_i.one_left) begin
          cmd_o.trim = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.pop = 1'b1;
          if (status_i.one_left) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
